/* design/tcp_reno_congestion_rto_unit_macros.svh */
// Assertion macros shared by the congestion and timeout unit.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef TCP_RENO_CONGESTION_RTO_UNIT_MACROS_SVH
`define TCP_RENO_CONGESTION_RTO_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// A condition that holds at every clock edge out of reset.
`define TCRC_ASSERT(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("tcrc check failed");

// A consequence that holds in the same cycle as its cause.
`define TCRC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tcrc check failed");

// A consequence that holds in the cycle after its cause.
`define TCRC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tcrc check failed");

`else

`define TCRC_ASSERT(lbl, expr)
`define TCRC_ASSERT_IMP(lbl, ante, cons)
`define TCRC_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

/* design/tcrc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package tcrc_pkg;

  // Field widths.
  localparam int unsigned OP_W   = 2;
  localparam int unsigned MODE_W = 2;
  localparam int unsigned DUP_W  = 2;
  localparam int unsigned MSS_W  = 16;
  localparam int unsigned WIN_W  = 24;
  localparam int unsigned RTO_W  = 24;
  localparam int unsigned CWND_W = 32;
  localparam int unsigned RTT_W  = 27;
  localparam int unsigned SQ_W   = 2 * MSS_W;
  localparam int unsigned NUM_W  = SQ_W + 16;
  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 32;

  // Default duplicate ACK count that triggers fast retransmit.
  localparam int unsigned DUP_THR_DEF = 3;

  // Divider: two quotient bits per cycle over the whole numerator.
  localparam int unsigned DIV_BITS   = 2;
  localparam int unsigned DIV_STEPS  = NUM_W / DIV_BITS;
  localparam int unsigned DIV_CNT_W  = $clog2(DIV_STEPS);

  // Event codes.
  localparam logic [OP_W-1:0] OP_DUPACK  = 2'd0;
  localparam logic [OP_W-1:0] OP_NEWACK  = 2'd1;
  localparam logic [OP_W-1:0] OP_TIMEOUT = 2'd2;
  localparam logic [OP_W-1:0] OP_INIT    = 2'd3;

  // Congestion modes.
  localparam logic [MODE_W-1:0] MODE_SS   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_AIMD = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FR   = 2'd2;

  // Largest window, Q24.8.
  localparam logic [CWND_W-1:0] CWND_SAT = 32'hFFFF_FF00;

  // Register indexes.
  localparam logic [2:0] REG_MSS      = 3'd0;
  localparam logic [2:0] REG_RWND     = 3'd1;
  localparam logic [2:0] REG_MIN_RTO  = 3'd2;
  localparam logic [2:0] REG_MAX_RTO  = 3'd3;
  localparam logic [2:0] REG_INIT_RTO = 3'd4;
  localparam logic [2:0] REG_FRX_EN   = 3'd5;
  localparam logic [2:0] REG_RTT_EN   = 3'd6;

  // Register reset values.
  localparam logic [MSS_W-1:0] RST_MSS      = 16'd1460;
  localparam logic [WIN_W-1:0] RST_RWND     = 24'd65536;
  localparam logic [RTO_W-1:0] RST_MIN_RTO  = 24'd10000;
  localparam logic [RTO_W-1:0] RST_MAX_RTO  = 24'd2000000;
  localparam logic [RTO_W-1:0] RST_INIT_RTO = 24'd50000;

  typedef struct packed {
    logic [MSS_W-1:0] mss;
    logic [WIN_W-1:0] rwnd;
    logic [RTO_W-1:0] min_rto;
    logic [RTO_W-1:0] max_rto;
    logic [RTO_W-1:0] init_rto;
    logic             frx_en;
    logic             rtt_en;
  } cfg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;
    logic rtt1;
    logic rtt2;
    logic rtt3;
    logic win_step;
    logic mul_step;
    logic div_init;
    logic div_step;
    logic add_step;
    logic load_out;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic rtt_go;
    logic aimd_go;
  } stat_t;

endpackage

`default_nettype wire

/* design/tcrc_cfg_regs.sv */
`timescale 1ns / 1ps
`default_nettype none

module tcrc_cfg_regs (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [tcrc_pkg::ADDR_W-1:0] paddr,
  input  wire logic [tcrc_pkg::DATA_W-1:0] pwdata,
  output logic      [tcrc_pkg::DATA_W-1:0] prdata,
  output logic                            pready,
  output tcrc_pkg::cfg_t                  cfg
);
  import tcrc_pkg::*;

  cfg_t       cfg_r;
  cfg_t       cfg_nxt;
  logic       wr_en;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;
  assign idx    = paddr[4:2];
  assign cfg    = cfg_r;

  // Register write decode.
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        REG_MSS:      cfg_nxt.mss      = pwdata[MSS_W-1:0];
        REG_RWND:     cfg_nxt.rwnd     = pwdata[WIN_W-1:0];
        REG_MIN_RTO:  cfg_nxt.min_rto  = pwdata[RTO_W-1:0];
        REG_MAX_RTO:  cfg_nxt.max_rto  = pwdata[RTO_W-1:0];
        REG_INIT_RTO: cfg_nxt.init_rto = pwdata[RTO_W-1:0];
        REG_FRX_EN:   cfg_nxt.frx_en   = pwdata[0];
        REG_RTT_EN:   cfg_nxt.rtt_en   = pwdata[0];
        default:      cfg_nxt          = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mss      <= RST_MSS;
      cfg_r.rwnd     <= RST_RWND;
      cfg_r.min_rto  <= RST_MIN_RTO;
      cfg_r.max_rto  <= RST_MAX_RTO;
      cfg_r.init_rto <= RST_INIT_RTO;
      cfg_r.frx_en   <= 1'b1;
      cfg_r.rtt_en   <= 1'b1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Read back.
  always_comb begin
    case (idx)
      REG_MSS:      prdata = {{(DATA_W-MSS_W){1'b0}}, cfg_r.mss};
      REG_RWND:     prdata = {{(DATA_W-WIN_W){1'b0}}, cfg_r.rwnd};
      REG_MIN_RTO:  prdata = {{(DATA_W-RTO_W){1'b0}}, cfg_r.min_rto};
      REG_MAX_RTO:  prdata = {{(DATA_W-RTO_W){1'b0}}, cfg_r.max_rto};
      REG_INIT_RTO: prdata = {{(DATA_W-RTO_W){1'b0}}, cfg_r.init_rto};
      REG_FRX_EN:   prdata = {{(DATA_W-1){1'b0}}, cfg_r.frx_en};
      REG_RTT_EN:   prdata = {{(DATA_W-1){1'b0}}, cfg_r.rtt_en};
      default:      prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

/* design/tcrc_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "tcp_reno_congestion_rto_unit_macros.svh"

module tcrc_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  wire logic            out_ready,
  input  wire tcrc_pkg::stat_t stat,
  output tcrc_pkg::cmd_t       cmd
);
  import tcrc_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CHK   = 4'd1;
  localparam logic [3:0] S_RTT1  = 4'd2;
  localparam logic [3:0] S_RTT2  = 4'd3;
  localparam logic [3:0] S_RTT3  = 4'd4;
  localparam logic [3:0] S_WSEL  = 4'd5;
  localparam logic [3:0] S_DINIT = 4'd6;
  localparam logic [3:0] S_DIV   = 4'd7;
  localparam logic [3:0] S_ADD   = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;

  logic [3:0]           state_r;
  logic [3:0]           state_nxt;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [DIV_CNT_W-1:0] cnt_nxt;
  logic                 out_valid_r;
  logic                 out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  // Sequencer: one event at a time through the RTT and window steps.
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_CHK;
        end
      end
      S_CHK: begin
        state_nxt = stat.rtt_go ? S_RTT1 : S_WSEL;
      end
      S_RTT1: begin
        cmd.rtt1  = 1'b1;
        state_nxt = S_RTT2;
      end
      S_RTT2: begin
        cmd.rtt2  = 1'b1;
        state_nxt = S_RTT3;
      end
      S_RTT3: begin
        cmd.rtt3  = 1'b1;
        state_nxt = S_WSEL;
      end
      S_WSEL: begin
        if (stat.aimd_go) begin
          cmd.mul_step = 1'b1;
          state_nxt    = S_DINIT;
        end else begin
          cmd.win_step = 1'b1;
          state_nxt    = S_DONE;
        end
      end
      S_DINIT: begin
        cmd.div_init = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
          state_nxt = S_ADD;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_ADD: begin
        cmd.add_step = 1'b1;
        state_nxt    = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Result register valid flag.
  always_comb begin
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `TCRC_ASSERT_NXT(a_one_item, in_valid && in_ready, !in_ready)
  `TCRC_ASSERT_NXT(a_load_sets_valid, cmd.load_out, out_valid)
  `TCRC_ASSERT_NXT(a_done_waits, state_r == S_DONE && out_valid_r && !out_ready,
                   state_r == S_DONE)
  `TCRC_ASSERT_IMP(a_div_count, state_r == S_DIV, cnt_r < DIV_CNT_W'(DIV_STEPS))

endmodule

`default_nettype wire

/* design/tcrc_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "tcp_reno_congestion_rto_unit_macros.svh"

module tcrc_datapath #(
  parameter int unsigned DUP_THRESHOLD = tcrc_pkg::DUP_THR_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire tcrc_pkg::cfg_t              cfg,
  input  wire tcrc_pkg::cmd_t              cmd,
  output tcrc_pkg::stat_t                  stat,
  input  wire logic [tcrc_pkg::OP_W-1:0]   in_operation,
  input  wire logic                        in_sample_valid,
  input  wire logic [tcrc_pkg::RTO_W-1:0]  in_sample_us,
  output logic      [tcrc_pkg::MODE_W-1:0] out_cong_mode,
  output logic      [tcrc_pkg::WIN_W-1:0]  out_cwnd_bytes,
  output logic      [tcrc_pkg::WIN_W-1:0]  out_ssthresh_bytes,
  output logic      [tcrc_pkg::RTO_W-1:0]  out_rto_us,
  output logic                             out_fast_retransmit,
  output logic                             out_restart_timer
);
  import tcrc_pkg::*;

  localparam logic [DUP_W-1:0] DUP_THR = DUP_W'(DUP_THRESHOLD);

  // Latched event.
  logic [OP_W-1:0]   op_r;
  logic              sv_r;
  logic [RTO_W-1:0]  samp_r;

  // Connection state.
  logic [MODE_W-1:0] mode_r,  mode_nxt;
  logic [CWND_W-1:0] cwnd_r,  cwnd_nxt;
  logic [WIN_W-1:0]  thr_r,   thr_nxt;
  logic [DUP_W-1:0]  dup_r,   dup_nxt;
  logic [RTT_W-1:0]  est_r,   est_nxt;
  logic [RTT_W-1:0]  dev_r,   dev_nxt;
  logic [RTO_W-1:0]  rto_r,   rto_nxt;
  logic              first_r, first_nxt;
  logic              frx_r,   frx_nxt;
  logic              rst_r,   rst_nxt;

  // Window increment arithmetic.
  logic [SQ_W-1:0]   sq_r;
  logic [CWND_W-1:0] rem_r,   rem_nxt;
  logic [NUM_W-1:0]  quo_r,   quo_nxt;

  // Shared intermediate values.
  logic [RTT_W-1:0]  samp_q3;
  logic [WIN_W-1:0]  half_thr;

  assign samp_q3      = {samp_r, 3'b000};
  assign half_thr     = (cwnd_r[31:9] < {7'd0, cfg.mss}) ? {8'd0, cfg.mss}
                                                         : {1'b0, cwnd_r[31:9]};
  assign stat.rtt_go  = (op_r == OP_NEWACK) && cfg.rtt_en && sv_r;
  assign stat.aimd_go = (op_r == OP_NEWACK) && (mode_r == MODE_AIMD);

  // State update for each command.
  always_comb begin
    logic [RTT_W-1:0]  est_base;
    logic [30:0]       est_sum;
    logic [RTT_W-1:0]  diff;
    logic [28:0]       dev_sum;
    logic [29:0]       r_sum;
    logic [RTT_W-1:0]  r_val;
    logic [DUP_W-1:0]  dup_inc;
    logic [24:0]       fr_sum;
    logic [32:0]       ss_sum;
    logic [CWND_W-1:0] ss_cwnd;
    logic [RTO_W:0]    to_rto;
    logic [CWND_W-1:0] room;
    logic [32:0]       shifted;

    mode_nxt  = mode_r;
    cwnd_nxt  = cwnd_r;
    thr_nxt   = thr_r;
    dup_nxt   = dup_r;
    est_nxt   = est_r;
    dev_nxt   = dev_r;
    rto_nxt   = rto_r;
    first_nxt = first_r;
    frx_nxt   = frx_r;
    rst_nxt   = rst_r;
    rem_nxt   = rem_r;
    quo_nxt   = quo_r;

    est_base = first_r ? samp_q3 : est_r;
    est_sum  = {1'b0, est_base, 3'b000} - {4'd0, est_base} + {4'd0, samp_q3} + 31'd4;
    diff     = (samp_q3 > est_r) ? (samp_q3 - est_r) : (est_r - samp_q3);
    dev_sum  = {1'b0, dev_r, 1'b0} + {2'd0, dev_r} + {2'd0, diff} + 29'd2;
    r_sum    = {3'd0, est_r} + {1'b0, dev_r, 2'b00} + 30'd4;
    r_val    = r_sum[29:3];
    dup_inc  = dup_r + 1'b1;
    fr_sum   = {1'b0, half_thr} + {9'd0, cfg.mss} + {8'd0, cfg.mss, 1'b0};
    ss_sum   = {1'b0, cwnd_r} + {9'd0, cfg.mss, 8'd0};
    ss_cwnd  = (ss_sum > {1'b0, CWND_SAT}) ? CWND_SAT : ss_sum[31:0];
    to_rto   = cfg.rtt_en ? {rto_r, 1'b0} : {1'b0, rto_r};
    room     = CWND_SAT - cwnd_r;
    shifted  = '0;

    // First RTT step: seed on the first sample, then smooth the estimate.
    if (cmd.rtt1) begin
      est_nxt   = est_sum[29:3];
      dev_nxt   = first_r ? {1'b0, samp_q3[RTT_W-1:1]} : dev_r;
      first_nxt = 1'b0;
    end

    // Second RTT step: smooth the deviation.
    if (cmd.rtt2) begin
      dev_nxt = dev_sum[28:2];
    end

    // Third RTT step: timeout from estimate and deviation, then clamp.
    if (cmd.rtt3) begin
      if (r_val < {3'd0, cfg.min_rto}) begin
        rto_nxt = cfg.min_rto;
      end else if (r_val > {3'd0, cfg.max_rto}) begin
        rto_nxt = cfg.max_rto;
      end else begin
        rto_nxt = r_val[RTO_W-1:0];
      end
    end

    // Window update in a single step for every case but a new ACK in AIMD.
    if (cmd.win_step) begin
      frx_nxt = 1'b0;
      rst_nxt = 1'b0;
      case (op_r)
        OP_DUPACK: begin
          if (cfg.frx_en) begin
            if (dup_inc == DUP_THR) begin
              dup_nxt = '0;
              rst_nxt = 1'b1;
              if (mode_r == MODE_SS || mode_r == MODE_AIMD) begin
                thr_nxt  = half_thr;
                cwnd_nxt = fr_sum[24] ? CWND_SAT : {fr_sum[23:0], 8'd0};
                mode_nxt = MODE_FR;
                frx_nxt  = 1'b1;
              end
            end else begin
              dup_nxt = dup_inc;
            end
          end
        end
        OP_NEWACK: begin
          dup_nxt = '0;
          rst_nxt = 1'b1;
          if (mode_r == MODE_SS) begin
            cwnd_nxt = ss_cwnd;
            if (ss_cwnd >= {thr_r, 8'd0}) begin
              mode_nxt = MODE_AIMD;
            end
          end else if (mode_r == MODE_FR) begin
            mode_nxt = MODE_AIMD;
            cwnd_nxt = {thr_r, 8'd0};
          end
        end
        OP_TIMEOUT: begin
          rto_nxt = (to_rto > {1'b0, cfg.max_rto}) ? cfg.max_rto : to_rto[RTO_W-1:0];
          rst_nxt = 1'b1;
          if (mode_r == MODE_SS) begin
            thr_nxt  = half_thr;
            mode_nxt = MODE_AIMD;
            cwnd_nxt = {half_thr, 8'd0};
          end else if (mode_r == MODE_AIMD || mode_r == MODE_FR) begin
            thr_nxt  = cfg.rwnd;
            mode_nxt = MODE_SS;
            cwnd_nxt = {8'd0, cfg.mss, 8'd0};
          end
        end
        OP_INIT: begin
          mode_nxt  = MODE_SS;
          cwnd_nxt  = {8'd0, cfg.mss, 8'd0};
          thr_nxt   = cfg.rwnd;
          dup_nxt   = '0;
          est_nxt   = {cfg.init_rto, 3'b000};
          dev_nxt   = '0;
          rto_nxt   = cfg.init_rto;
          first_nxt = 1'b1;
        end
        default: begin
          mode_nxt = mode_r;
        end
      endcase
    end

    // Divider setup: numerator is the squared segment size in Q16.
    if (cmd.div_init) begin
      quo_nxt = {sq_r, 16'd0};
      rem_nxt = '0;
    end

    // Restoring division, two quotient bits per cycle.
    if (cmd.div_step) begin
      for (int k = 0; k < DIV_BITS; k++) begin
        shifted = {rem_nxt, quo_nxt[NUM_W-1]};
        quo_nxt = {quo_nxt[NUM_W-2:0], 1'b0};
        if (shifted >= {1'b0, cwnd_r}) begin
          shifted    = shifted - {1'b0, cwnd_r};
          quo_nxt[0] = 1'b1;
        end
        rem_nxt = shifted[CWND_W-1:0];
      end
    end

    // AIMD growth with saturation.
    if (cmd.add_step) begin
      if (quo_r >= {{(NUM_W-CWND_W){1'b0}}, room}) begin
        cwnd_nxt = CWND_SAT;
      end else begin
        cwnd_nxt = cwnd_r + quo_r[CWND_W-1:0];
      end
      dup_nxt = '0;
      rst_nxt = 1'b1;
      frx_nxt = 1'b0;
    end
  end

  // Connection state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_SS;
      cwnd_r  <= {8'd0, RST_MSS, 8'd0};
      thr_r   <= RST_RWND;
      dup_r   <= '0;
      est_r   <= {RST_INIT_RTO, 3'b000};
      dev_r   <= '0;
      rto_r   <= RST_INIT_RTO;
      first_r <= 1'b1;
      frx_r   <= 1'b0;
      rst_r   <= 1'b0;
    end else begin
      mode_r  <= mode_nxt;
      cwnd_r  <= cwnd_nxt;
      thr_r   <= thr_nxt;
      dup_r   <= dup_nxt;
      est_r   <= est_nxt;
      dev_r   <= dev_nxt;
      rto_r   <= rto_nxt;
      first_r <= first_nxt;
      frx_r   <= frx_nxt;
      rst_r   <= rst_nxt;
    end
  end

  // Event capture, squaring and divider registers.
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_r   <= in_operation;
      sv_r   <= in_sample_valid;
      samp_r <= in_sample_us;
    end
    if (cmd.mul_step) begin
      sq_r <= SQ_W'(cfg.mss) * SQ_W'(cfg.mss);
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_cong_mode       <= mode_r;
      out_cwnd_bytes      <= cwnd_r[CWND_W-1:8];
      out_ssthresh_bytes  <= thr_r;
      out_rto_us          <= rto_r;
      out_fast_retransmit <= frx_r;
      out_restart_timer   <= rst_r;
    end
  end

  `TCRC_ASSERT(a_cwnd_sat, cwnd_r <= CWND_SAT)
  `TCRC_ASSERT_NXT(a_timeout_clamp, cmd.win_step && op_r == OP_TIMEOUT,
                   rto_r <= cfg.max_rto)
  `TCRC_ASSERT_NXT(a_init_quiet, cmd.win_step && op_r == OP_INIT, !frx_r && !rst_r)

endmodule

`default_nettype wire

/* design/tcp_reno_congestion_rto_unit.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel  Direction  Handshake           Payload
// in       input      in_valid/in_ready   operation, sample_valid, sample_us
// out      output     out_valid/out_ready cong_mode, cwnd_bytes, ssthresh_bytes,
//                                          rto_us, fast_retransmit, restart_timer
// cfg      input      psel/penable/pready paddr, pwdata, prdata (APB, 7 registers)
//
// One event is in work at a time. A new ACK in AIMD mode passes check, the RTT steps
// if it has a sample, window select, divider setup, the divider steps and the add;
// the restoring divider for the window increment (two quotient bits a cycle over 48
// bits) dominates. Every other event passes check, the RTT steps if it is a new ACK
// with a sample, and a window step; the next transfer in can come in the cycle after
// the result register loads. A waiting result does not block the next transfer in;
// that event stalls in its last step until the result register is free. Reset is
// synchronous and needs no clearing pass.

module tcp_reno_congestion_rto_unit #(
  parameter int unsigned DUP_THRESHOLD = tcrc_pkg::DUP_THR_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [tcrc_pkg::OP_W-1:0]   in_operation,
  input  wire logic                        in_sample_valid,
  input  wire logic [tcrc_pkg::RTO_W-1:0]  in_sample_us,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic      [tcrc_pkg::MODE_W-1:0] out_cong_mode,
  output logic      [tcrc_pkg::WIN_W-1:0]  out_cwnd_bytes,
  output logic      [tcrc_pkg::WIN_W-1:0]  out_ssthresh_bytes,
  output logic      [tcrc_pkg::RTO_W-1:0]  out_rto_us,
  output logic                             out_fast_retransmit,
  output logic                             out_restart_timer,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [tcrc_pkg::ADDR_W-1:0] paddr,
  input  wire logic [tcrc_pkg::DATA_W-1:0] pwdata,
  output logic      [tcrc_pkg::DATA_W-1:0] prdata,
  output logic                             pready
);
  import tcrc_pkg::*;

  cfg_t  cfg;
  cmd_t  cmd;
  stat_t stat;

  tcrc_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tcrc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  tcrc_datapath #(
    .DUP_THRESHOLD (DUP_THRESHOLD)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg                 (cfg),
    .cmd                 (cmd),
    .stat                (stat),
    .in_operation        (in_operation),
    .in_sample_valid     (in_sample_valid),
    .in_sample_us        (in_sample_us),
    .out_cong_mode       (out_cong_mode),
    .out_cwnd_bytes      (out_cwnd_bytes),
    .out_ssthresh_bytes  (out_ssthresh_bytes),
    .out_rto_us          (out_rto_us),
    .out_fast_retransmit (out_fast_retransmit),
    .out_restart_timer   (out_restart_timer)
  );

endmodule

`default_nettype wire

/* tb/tb.sv */
`timescale 1ns / 1ps

module tb;
  import tcrc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned LONG_HOLD   = 300;
  localparam int unsigned SETTLE      = 60;
  localparam int unsigned SHOW_LIMIT  = 10;

  // One result transfer: the state after the event plus the two strobes.
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [WIN_W-1:0]  cwnd;
    logic [WIN_W-1:0]  ssthresh;
    logic [RTO_W-1:0]  rto;
    logic              frx;
    logic              restart;
  } reno_report_t;

  // Tracks the Reno window and timeout state and holds the reports it expects.
  class reno_window_tracker;
    logic [MSS_W-1:0]  mss;
    logic [WIN_W-1:0]  rwnd;
    logic [RTO_W-1:0]  min_rto;
    logic [RTO_W-1:0]  max_rto;
    logic [RTO_W-1:0]  init_rto;
    logic              frx_en;
    logic              rtt_en;

    logic [MODE_W-1:0] mode;
    logic [CWND_W-1:0] cwnd;
    logic [WIN_W-1:0]  thresh;
    logic [DUP_W-1:0]  dup_cnt;
    logic [RTT_W-1:0]  est;
    logic [RTT_W-1:0]  dev;
    logic [RTO_W-1:0]  rto;
    logic              first;

    reno_report_t      expected_reports[$];
    int unsigned       fail_count;

    function new();
      mss = RST_MSS;
      rwnd = RST_RWND;
      min_rto = RST_MIN_RTO;
      max_rto = RST_MAX_RTO;
      init_rto = RST_INIT_RTO;
      frx_en = 1'b1;
      rtt_en = 1'b1;
      fail_count = 0;
      reload();
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] val);
      case (idx)
        REG_MSS:      mss = val[MSS_W-1:0];
        REG_RWND:     rwnd = val[WIN_W-1:0];
        REG_MIN_RTO:  min_rto = val[RTO_W-1:0];
        REG_MAX_RTO:  max_rto = val[RTO_W-1:0];
        REG_INIT_RTO: init_rto = val[RTO_W-1:0];
        REG_FRX_EN:   frx_en = val[0];
        REG_RTT_EN:   rtt_en = val[0];
        default: ;
      endcase
    endfunction

    function logic [CWND_W-1:0] clamp_window(logic [63:0] q8);
      return (q8 > 64'(CWND_SAT)) ? CWND_SAT : q8[31:0];
    endfunction

    // Half the window in whole bytes, never below one segment.
    function logic [WIN_W-1:0] half_window();
      logic [WIN_W-1:0] t;
      t = WIN_W'(cwnd >> 9);
      return (t < WIN_W'(mss)) ? WIN_W'(mss) : t;
    endfunction

    function void reload();
      mode = MODE_SS;
      cwnd = clamp_window(64'(mss) << 8);
      thresh = rwnd;
      dup_cnt = '0;
      est = {init_rto, 3'b000};
      dev = '0;
      rto = init_rto;
      first = 1'b1;
    endfunction

    // Jacobson smoothing in eighths of a microsecond, then the clamped timeout.
    function void absorb_sample(logic [RTO_W-1:0] sus);
      logic [63:0] s, e, d, diff, x;
      s = 64'(sus) << 3;
      if (first) begin
        est = s[RTT_W-1:0];
        dev = s[RTT_W:1];
        first = 1'b0;
      end
      e = (64'd7 * 64'(est) + s + 64'd4) >> 3;
      diff = (s > e) ? s - e : e - s;
      d = (64'd3 * 64'(dev) + diff + 64'd2) >> 2;
      est = e[RTT_W-1:0];
      dev = d[RTT_W-1:0];
      x = (e + 64'd4 * d + 64'd4) >> 3;
      if (x < 64'(min_rto)) begin
        x = 64'(min_rto);
      end else if (x > 64'(max_rto)) begin
        x = 64'(max_rto);
      end
      rto = x[RTO_W-1:0];
    endfunction

    // Applies one accepted event and queues the report it must produce.
    function void take_event(logic [OP_W-1:0] op, logic sv, logic [RTO_W-1:0] sus);
      reno_report_t r;
      logic frx, restart;
      logic [63:0] num, inc, room, x;
      frx = 1'b0;
      restart = 1'b0;
      case (op)
        OP_DUPACK: begin
          if (frx_en) begin
            dup_cnt = dup_cnt + 2'd1;
            if (dup_cnt == DUP_W'(DUP_THR_DEF)) begin
              dup_cnt = '0;
              restart = 1'b1;
              if (mode == MODE_SS || mode == MODE_AIMD) begin
                thresh = half_window();
                cwnd = clamp_window((64'(thresh) + 64'd3 * 64'(mss)) << 8);
                mode = MODE_FR;
                frx = 1'b1;
              end
            end
          end
        end
        OP_NEWACK: begin
          dup_cnt = '0;
          if (rtt_en && sv) begin
            absorb_sample(sus);
          end
          restart = 1'b1;
          if (mode == MODE_SS) begin
            cwnd = clamp_window(64'(cwnd) + (64'(mss) << 8));
            if (64'(cwnd) >= (64'(thresh) << 8)) begin
              mode = MODE_AIMD;
            end
          end else if (mode == MODE_AIMD) begin
            // A zero window makes the quotient all ones, which saturates.
            num = (64'(mss) * 64'(mss)) << 16;
            inc = (cwnd == '0) ? '1 : num / 64'(cwnd);
            room = 64'(CWND_SAT) - 64'((cwnd > CWND_SAT) ? CWND_SAT : cwnd);
            cwnd = (inc >= room) ? CWND_SAT : cwnd + inc[31:0];
          end else if (mode == MODE_FR) begin
            mode = MODE_AIMD;
            cwnd = clamp_window(64'(thresh) << 8);
          end
        end
        OP_TIMEOUT: begin
          x = 64'(rto);
          if (rtt_en) begin
            x = x << 1;
          end
          if (x > 64'(max_rto)) begin
            x = 64'(max_rto);
          end
          rto = x[RTO_W-1:0];
          restart = 1'b1;
          if (mode == MODE_SS) begin
            thresh = half_window();
            mode = MODE_AIMD;
            cwnd = clamp_window(64'(thresh) << 8);
          end else if (mode == MODE_AIMD || mode == MODE_FR) begin
            thresh = rwnd;
            mode = MODE_SS;
            cwnd = clamp_window(64'(mss) << 8);
          end
        end
        default: begin
          reload();
        end
      endcase
      r.mode = mode;
      r.cwnd = cwnd[31:8];
      r.ssthresh = thresh;
      r.rto = rto;
      r.frx = frx;
      r.restart = restart;
      expected_reports.push_back(r);
    endfunction

    function int unsigned outstanding();
      return expected_reports.size();
    endfunction

    // Compares one result transfer with the oldest expected report.
    function void compare_report(reno_report_t got);
      reno_report_t want;
      if (expected_reports.size() == 0) begin
        fail_count++;
        if (fail_count <= SHOW_LIMIT) begin
          $display("unexpected result: mode %0d cwnd %0d ssthresh %0d rto %0d frx %0b rst %0b",
                   got.mode, got.cwnd, got.ssthresh, got.rto, got.frx, got.restart);
        end
        return;
      end
      want = expected_reports.pop_front();
      if (got.mode !== want.mode || got.cwnd !== want.cwnd ||
          got.ssthresh !== want.ssthresh || got.rto !== want.rto ||
          got.frx !== want.frx || got.restart !== want.restart) begin
        fail_count++;
        if (fail_count <= SHOW_LIMIT) begin
          $display("mismatch: expected mode %0d cwnd %0d ssthresh %0d rto %0d frx %0b rst %0b",
                   want.mode, want.cwnd, want.ssthresh, want.rto, want.frx, want.restart);
          $display("          actual   mode %0d cwnd %0d ssthresh %0d rto %0d frx %0b rst %0b",
                   got.mode, got.cwnd, got.ssthresh, got.rto, got.frx, got.restart);
        end
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic [OP_W-1:0]     in_operation;
  logic                in_sample_valid;
  logic [RTO_W-1:0]    in_sample_us;
  logic                out_valid;
  logic                out_ready;
  logic [MODE_W-1:0]   out_cong_mode;
  logic [WIN_W-1:0]    out_cwnd_bytes;
  logic [WIN_W-1:0]    out_ssthresh_bytes;
  logic [RTO_W-1:0]    out_rto_us;
  logic                out_fast_retransmit;
  logic                out_restart_timer;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [DATA_W-1:0]   pwdata;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  reno_window_tracker  trk = new();
  int unsigned         cycle_count = 0;
  bit                  idle_on = 1'b1;
  bit                  hold_request = 1'b0;

  tcp_reno_congestion_rto_unit u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_operation        (in_operation),
    .in_sample_valid     (in_sample_valid),
    .in_sample_us        (in_sample_us),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_cong_mode       (out_cong_mode),
    .out_cwnd_bytes      (out_cwnd_bytes),
    .out_ssthresh_bytes  (out_ssthresh_bytes),
    .out_rto_us          (out_rto_us),
    .out_fast_retransmit (out_fast_retransmit),
    .out_restart_timer   (out_restart_timer),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready)
  );

  always #1 clk = ~clk;

  // The run ends here if the block stops making progress.
  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Check each result transfer first, then record any input transfer of the same edge.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      trk.compare_report({out_cong_mode, out_cwnd_bytes, out_ssthresh_bytes, out_rto_us,
                          out_fast_retransmit, out_restart_timer});
    end
    if (rst_n && in_valid && in_ready) begin
      trk.take_event(in_operation, in_sample_valid, in_sample_us);
    end
  end

  // Result side: random stall bursts, plus one long hold when asked for.
  initial begin
    int hold_left;
    hold_left = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ready = 1'b0;
        hold_left--;
      end else if (hold_request) begin
        hold_request = 1'b0;
        hold_left = int'(LONG_HOLD) - 1;
        out_ready = 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        hold_left = int'($urandom_range(0, 7));
        out_ready = 1'b0;
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  // Offers one event and returns once its transfer has happened.
  task automatic send_item(logic [OP_W-1:0] op, logic sv, logic [RTO_W-1:0] sus);
    int gap;
    gap = 0;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      gap = int'($urandom_range(1, 8));
    end
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_operation = op;
    in_sample_valid = sv;
    in_sample_us = sus;
    do @(posedge clk); while (!in_ready);
  endtask

  // Stops offering and waits until every expected report has come back.
  task automatic wait_for_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (trk.outstanding() != 0) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = val;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    trk.set_reg(idx, val);
  endtask

  // Writes every register; only called with the block idle.
  task automatic configure(logic [15:0] mss, logic [23:0] rwnd, logic [23:0] min_r,
                           logic [23:0] max_r, logic [23:0] init_r, bit frx, bit rtt);
    wait_for_results();
    repeat (4) @(negedge clk);
    write_reg(REG_MSS, 32'(mss));
    write_reg(REG_RWND, 32'(rwnd));
    write_reg(REG_MIN_RTO, 32'(min_r));
    write_reg(REG_MAX_RTO, 32'(max_r));
    write_reg(REG_INIT_RTO, 32'(init_r));
    write_reg(REG_FRX_EN, 32'(frx));
    write_reg(REG_RTT_EN, 32'(rtt));
  endtask

  task automatic configure_random(bit enables_on);
    logic [23:0] min_r;
    min_r = 24'($urandom_range(1, 50000));
    configure(16'($urandom_range(1, 65535)), 24'($urandom_range(1, 24'hFFFFFF)), min_r,
              24'($urandom_range(min_r, 24'hFFFFFF)), 24'($urandom_range(1, 200000)),
              enables_on | 1'($urandom_range(0, 1)), enables_on | 1'($urandom_range(0, 1)));
  endtask

  // RTT samples favor realistic values but keep the extremes and full-width noise.
  function automatic logic [RTO_W-1:0] rand_sample();
    int sel;
    sel = int'($urandom_range(0, 9));
    if (sel == 0) begin
      return '0;
    end else if (sel == 1) begin
      return '1;
    end else if (sel < 6) begin
      return RTO_W'($urandom_range(1000, 200000));
    end
    return RTO_W'($urandom());
  endfunction

  // Random events: triple duplicate bursts drive fast recovery, new ACKs drive growth.
  task automatic run_phase(int n, int burst_pct, int ack_pct);
    int sent, pick, kind;
    sent = 0;
    while (sent < n) begin
      pick = int'($urandom_range(0, 99));
      if (pick < burst_pct) begin
        repeat (3) send_item(OP_DUPACK, 1'($urandom_range(0, 1)), rand_sample());
        sent += 3;
      end else if (pick < burst_pct + ack_pct) begin
        send_item(OP_NEWACK, $urandom_range(0, 3) != 0, rand_sample());
        sent++;
      end else begin
        kind = int'($urandom_range(0, 9));
        if (kind < 5) begin
          send_item(OP_DUPACK, 1'($urandom_range(0, 1)), rand_sample());
        end else if (kind < 9) begin
          send_item(OP_TIMEOUT, 1'($urandom_range(0, 1)), rand_sample());
        end else begin
          send_item(OP_INIT, 1'($urandom_range(0, 1)), rand_sample());
        end
        sent++;
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_operation = OP_INIT;
    in_sample_valid = 1'b0;
    in_sample_us = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed events at the reset configuration: fast retransmit, recovery exit,
    // first sample, sample extremes, ignored sample, both timeout paths.
    send_item(OP_INIT, 1'b0, '0);
    repeat (3) send_item(OP_DUPACK, 1'b0, '0);
    repeat (3) send_item(OP_DUPACK, 1'b1, '1);
    send_item(OP_NEWACK, 1'b1, '0);
    send_item(OP_NEWACK, 1'b1, '1);
    send_item(OP_NEWACK, 1'b0, '1);
    send_item(OP_NEWACK, 1'b1, 24'd20000);
    send_item(OP_TIMEOUT, 1'b0, '0);
    send_item(OP_TIMEOUT, 1'b1, 24'h555555);
    send_item(OP_TIMEOUT, 1'b0, '0);
    send_item(OP_NEWACK, 1'b1, 24'h555555);
    send_item(OP_NEWACK, 1'b1, 24'hAAAAAA);
    send_item(OP_DUPACK, 1'b0, '0);
    send_item(OP_NEWACK, 1'b0, '0);
    repeat (2) send_item(OP_DUPACK, 1'b0, '0);
    send_item(OP_INIT, 1'b1, '1);

    // Reset values written back explicitly, with one long result-side hold.
    configure(16'd1460, 24'd65536, 24'd10000, 24'd2000000, 24'd50000, 1'b1, 1'b1);
    run_phase(20, 12, 45);
    hold_request = 1'b1;
    run_phase(80, 12, 45);

    // Largest segment and receive window: slow start grows into window saturation.
    configure(16'hFFFF, 24'hFFFFFF, 24'd1, 24'hFFFFFF, 24'hFFFFFF, 1'b1, 1'b1);
    send_item(OP_INIT, 1'b0, '0);
    run_phase(265, 0, 100);
    run_phase(30, 20, 50);

    // Minimum timeout above the maximum; the minimum wins on small estimates.
    configure(16'd1, 24'd1, 24'hFFFFFF, 24'd1, 24'd1, 1'b1, 1'b1);
    send_item(OP_INIT, 1'b0, '0);
    run_phase(70, 12, 45);

    // Zero segment and window: a zero window in AIMD saturates on the next ACK.
    configure(16'd0, 24'd0, 24'd0, 24'hFFFFFF, 24'd0, 1'b1, 1'b1);
    send_item(OP_INIT, 1'b0, '0);
    send_item(OP_NEWACK, 1'b1, '0);
    send_item(OP_NEWACK, 1'b0, '0);
    send_item(OP_INIT, 1'b0, '0);
    send_item(OP_TIMEOUT, 1'b0, '0);
    send_item(OP_NEWACK, 1'b1, 24'd5);
    run_phase(50, 12, 45);

    // Duplicate counting and RTT estimation both disabled.
    configure(16'd536, 24'd8000, 24'd200, 24'd60000, 24'd3000, 1'b0, 1'b0);
    run_phase(70, 12, 45);

    // Random settings; the sender drains completely once in the middle.
    configure_random(1'b0);
    run_phase(40, 12, 45);
    wait_for_results();
    run_phase(40, 12, 45);
    configure_random(1'b0);
    run_phase(70, 12, 45);

    // Closing stretch at full rate on both sides.
    configure_random(1'b1);
    idle_on = 1'b0;
    run_phase(90, 12, 45);

    wait_for_results();
    repeat (SETTLE) @(posedge clk);
    if (trk.fail_count == 0 && trk.outstanding() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
